[rtl/swerve_module_kinematics_assert.svh]
// Assertion macros for the swerve kinematics RTL.
// No dependencies; included by swk_ctrl, the file that carries assertions.
`ifndef SWERVE_MODULE_KINEMATICS_ASSERT_SVH
`define SWERVE_MODULE_KINEMATICS_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SWK_ASSERT_NOW(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("swk assertion failed");

// antecedent implies consequent in the next cycle
`define SWK_ASSERT_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("swk assertion failed");

`endif

[rtl/swk_pkg.sv]
// Package for swerve kinematics: widths, constants, command struct, atan table, deadzone function.
// No dependencies.
`timescale 1ns / 1ps
package swk_pkg;
	localparam int CORDIC_ITERS   = 16;
	localparam int DEADZONE       = 3277;
	localparam int SQRT_STEPS     = 28;
	localparam int STEP_W         = 5;
	localparam int VEC_W          = 42;
	localparam int CRD_W          = 45;
	localparam int Z_W            = 26;
	localparam int CMP_W          = 29;
	localparam int SQ_W           = 56;
	localparam logic [21:0] RAD_TO_DEG_Q16 = 22'd3754936;
	localparam logic signed [Z_W-1:0] NINETY_Q16 = 26'sd5898240;
	localparam logic signed [17:0] ANGLE_LOW  = -18'sd34560;
	localparam logic signed [17:0] ANGLE_HIGH = 18'sd11520;
	localparam logic signed [34:0] COMP_LIMIT = 35'sd134217728;

	localparam logic [2:0] REG_MAX_SPEED = 3'd0;
	localparam logic [2:0] REG_MAX_ROT   = 3'd1;
	localparam logic [2:0] REG_DIST_FL   = 3'd2;
	localparam logic [2:0] REG_DIST_FR   = 3'd3;
	localparam logic [2:0] REG_DIST_BL   = 3'd4;
	localparam logic [2:0] REG_DIST_BR   = 3'd5;
	localparam logic [2:0] REG_MOUNT_COS = 3'd6;
	localparam logic [2:0] REG_MOUNT_SIN = 3'd7;

	typedef struct packed {
		logic load;
		logic pre;
		logic m1;
		logic m2;
		logic m3;
		logic m4;
		logic m5;
		logic sq_init;
		logic step;
		logic fin;
		logic wr;
		logic publish;
		logic [1:0] mod;
		logic [STEP_W-1:0] k;
	} cmd_t;

	function automatic logic signed [Z_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			5'd0:  r = 26'sd2949120;
			5'd1:  r = 26'sd1740967;
			5'd2:  r = 26'sd919879;
			5'd3:  r = 26'sd466945;
			5'd4:  r = 26'sd234379;
			5'd5:  r = 26'sd117304;
			5'd6:  r = 26'sd58666;
			5'd7:  r = 26'sd29335;
			5'd8:  r = 26'sd14668;
			5'd9:  r = 26'sd7334;
			5'd10: r = 26'sd3667;
			5'd11: r = 26'sd1833;
			5'd12: r = 26'sd917;
			5'd13: r = 26'sd458;
			5'd14: r = 26'sd229;
			5'd15: r = 26'sd115;
			5'd16: r = 26'sd57;
			5'd17: r = 26'sd29;
			5'd18: r = 26'sd14;
			5'd19: r = 26'sd7;
			5'd20: r = 26'sd4;
			5'd21: r = 26'sd2;
			5'd22: r = 26'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] dz(input logic signed [15:0] v);
		logic signed [16:0] a;
		a = v[15] ? -{v[15], v} : {v[15], v};
		return (v != 16'sd0 && a < 17'(DEADZONE)) ? 16'sd0 : v;
	endfunction
endpackage

[rtl/swk_ctrl.sv]
// Controller FSM for swerve kinematics: sequences the datapath per module.
// Depends on swk_pkg and swerve_module_kinematics_assert.svh.
`timescale 1ns / 1ps
`include "swerve_module_kinematics_assert.svh"
module swk_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output swk_pkg::cmd_t cmd
);
	import swk_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PRE, S_M1, S_M2, S_M3, S_M4, S_M5, S_SQI, S_IT, S_FIN, S_WR, S_PUB
	} state_t;

	state_t state_q;
	logic [1:0] mod_q;
	logic [STEP_W-1:0] k_q;
	logic in_ready_q, out_valid_q;
	logic pub;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;
	assign pub = (state_q == S_PUB) && (!out_valid_q || out_ready);

	always_comb begin
		cmd = '0;
		cmd.load    = in_valid && in_ready_q;
		cmd.pre     = state_q == S_PRE;
		cmd.m1      = state_q == S_M1;
		cmd.m2      = state_q == S_M2;
		cmd.m3      = state_q == S_M3;
		cmd.m4      = state_q == S_M4;
		cmd.m5      = state_q == S_M5;
		cmd.sq_init = state_q == S_SQI;
		cmd.step    = state_q == S_IT;
		cmd.fin     = state_q == S_FIN;
		cmd.wr      = state_q == S_WR;
		cmd.publish = pub;
		cmd.mod     = mod_q;
		cmd.k       = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mod_q       <= '0;
			k_q         <= '0;
			in_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pub)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					in_ready_q <= !(in_valid && in_ready_q);
					if (in_valid && in_ready_q)
						state_q <= S_PRE;
				end
				S_PRE: begin
					mod_q   <= '0;
					state_q <= S_M1;
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: state_q <= S_M5;
				S_M5: state_q <= S_SQI;
				S_SQI: begin
					k_q     <= '0;
					state_q <= S_IT;
				end
				S_IT: begin
					k_q <= k_q + 1'b1;
					if (k_q == STEP_W'(SQRT_STEPS - 1))
						state_q <= S_FIN;
				end
				S_FIN: state_q <= S_WR;
				S_WR: begin
					mod_q <= mod_q + 1'b1;
					state_q <= (mod_q == 2'd3) ? S_PUB : S_M1;
				end
				S_PUB: begin
					if (pub) begin
						in_ready_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`SWK_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready_q, !in_ready_q)
	`SWK_ASSERT_NOW(a_step_bound, clk, arst_n, state_q == S_IT, k_q < STEP_W'(SQRT_STEPS))
	`SWK_ASSERT_NEXT(a_hold_out, clk, arst_n, out_valid_q && !out_ready, out_valid_q)
	`SWK_ASSERT_NOW(a_busy_not_ready, clk, arst_n, state_q != S_IDLE, !in_ready_q)
endmodule

[rtl/swk_dp.sv]
// Datapath for swerve kinematics: config registers, vector products,
// iterative square root and CORDIC, output registers. Depends on swk_pkg.
`timescale 1ns / 1ps
module swk_dp (
	input  logic clk,
	input  logic arst_n,
	input  swk_pkg::cmd_t cmd,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic signed [15:0] stick_x,
	input  logic signed [15:0] stick_y,
	input  logic signed [15:0] stick_rot,
	output logic [23:0] speed_front_left,
	output logic [23:0] speed_front_right,
	output logic [23:0] speed_back_left,
	output logic [23:0] speed_back_right,
	output logic signed [16:0] angle_front_left,
	output logic signed [16:0] angle_front_right,
	output logic signed [16:0] angle_back_left,
	output logic signed [16:0] angle_back_right,
	output logic moving
);
	import swk_pkg::*;

	logic [15:0] max_speed_q, max_rot_q, cos_q, sin_q;
	logic [15:0] dist_q [4];
	logic signed [15:0] held_x_q, held_y_q, held_rot_q;
	logic signed [15:0] x_q, y_q, r_q;
	logic moving_q;
	logic signed [31:0] tx_q, ty_q;
	logic signed [32:0] rv_q;
	logic signed [48:0] rd_q;
	logic signed [64:0] pxp_q, pyp_q;
	logic signed [VEC_W-1:0] vx_q, vy_q;
	logic signed [CMP_W-1:0] ca_q, cb_q;
	logic [SQ_W-1:0] aa_q, bb_q, n_q, res_q, bit_q;
	logic signed [CRD_W-1:0] cx_q, cy_q;
	logic signed [Z_W-1:0] z_q;
	logic nz_q;
	logic [49:0] sp_q;
	logic [23:0] spd_r_q [4];
	logic signed [16:0] ang_r_q [4];
	logic [23:0] spd_o_q [4];
	logic signed [16:0] ang_o_q [4];

	logic signed [15:0] dx, dy, dr;
	logic signed [41:0] px, py;
	logic signed [VEC_W-1:0] vx_n, vy_n;
	logic signed [CMP_W-1:0] ca_n, cb_n;
	logic [SQ_W:0] sq_sum;
	logic signed [CRD_W-1:0] sdx, sdy;
	logic [25:0] s_full;
	logic signed [Z_W:0] a_pre;
	logic signed [17:0] a_sh, a_cl;

	function automatic logic signed [CMP_W-1:0] clampc(input logic signed [VEC_W-1:0] v);
		logic signed [34:0] q;
		q = 35'((v + VEC_W'(64)) >>> 7);
		if (q > COMP_LIMIT) q = COMP_LIMIT;
		if (q < -COMP_LIMIT) q = -COMP_LIMIT;
		return q[CMP_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= 16'd256;
			max_rot_q   <= 16'd256;
			dist_q[0]   <= 16'd256;
			dist_q[1]   <= 16'd256;
			dist_q[2]   <= 16'd256;
			dist_q[3]   <= 16'd256;
			cos_q       <= 16'd23170;
			sin_q       <= 16'd23170;
			held_x_q    <= '0;
			held_y_q    <= '0;
			held_rot_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_SPEED: max_speed_q <= cfg_wdata;
					REG_MAX_ROT:   max_rot_q   <= cfg_wdata;
					REG_DIST_FL:   dist_q[0]   <= cfg_wdata;
					REG_DIST_FR:   dist_q[1]   <= cfg_wdata;
					REG_DIST_BL:   dist_q[2]   <= cfg_wdata;
					REG_DIST_BR:   dist_q[3]   <= cfg_wdata;
					REG_MOUNT_COS: cos_q       <= cfg_wdata;
					REG_MOUNT_SIN: sin_q       <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.load && (dx != 0 || dy != 0 || dr != 0)) begin
				held_x_q   <= dx;
				held_y_q   <= dy;
				held_rot_q <= dr;
			end
		end
	end

	assign dx = dz(stick_x);
	assign dy = dz(stick_y);
	assign dr = dz(stick_rot);

	assign px = 42'((pxp_q + 65'sd4194304) >>> 23);
	assign py = 42'((pyp_q + 65'sd4194304) >>> 23);
	assign vx_n = cmd.mod[1] ? VEC_W'(tx_q) - px : VEC_W'(tx_q) + px;
	assign vy_n = cmd.mod[0] ? VEC_W'(ty_q) - py : VEC_W'(ty_q) + py;
	assign ca_n = clampc(vx_q);
	assign cb_n = clampc(vy_q);
	assign sq_sum = {1'b0, res_q} + {1'b0, bit_q};
	assign sdx = cy_q >>> cmd.k;
	assign sdy = cx_q >>> cmd.k;
	assign s_full = 26'((sp_q + 50'd8388608) >> 24);
	assign a_pre = Z_W'(z_q) - (Z_W+1)'(NINETY_Q16) + (Z_W+1)'(256);
	assign a_sh = 18'(a_pre >>> 9);
	assign a_cl = (a_sh < ANGLE_LOW) ? ANGLE_LOW : ((a_sh > ANGLE_HIGH) ? ANGLE_HIGH : a_sh);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (dx == 0 && dy == 0 && dr == 0) begin
				x_q <= held_x_q;
				y_q <= held_y_q;
				r_q <= held_rot_q;
				moving_q <= 1'b0;
			end else begin
				x_q <= dx;
				y_q <= dy;
				r_q <= dr;
				moving_q <= 1'b1;
			end
		end
		if (cmd.pre) begin
			tx_q <= x_q * $signed({1'b0, max_speed_q});
			ty_q <= y_q * $signed({1'b0, max_speed_q});
			rv_q <= r_q * $signed({1'b0, max_rot_q});
		end
		if (cmd.m1)
			rd_q <= rv_q * $signed({1'b0, dist_q[cmd.mod]});
		if (cmd.m2) begin
			pxp_q <= rd_q * $signed(cos_q);
			pyp_q <= rd_q * $signed(sin_q);
		end
		if (cmd.m3) begin
			vx_q <= vx_n;
			vy_q <= vy_n;
		end
		if (cmd.m4) begin
			ca_q <= ca_n;
			cb_q <= cb_n;
			nz_q <= (vx_q != 0) || (vy_q != 0);
			if (vx_q < 0) begin
				if (vy_q >= 0) begin
					cx_q <= CRD_W'(vy_q);
					cy_q <= -CRD_W'(vx_q);
					z_q  <= NINETY_Q16;
				end else begin
					cx_q <= -CRD_W'(vy_q);
					cy_q <= CRD_W'(vx_q);
					z_q  <= -NINETY_Q16;
				end
			end else begin
				cx_q <= CRD_W'(vx_q);
				cy_q <= CRD_W'(vy_q);
				z_q  <= '0;
			end
		end
		if (cmd.m5) begin
			aa_q <= SQ_W'(ca_q * ca_q);
			bb_q <= SQ_W'(cb_q * cb_q);
		end
		if (cmd.sq_init) begin
			n_q   <= aa_q + bb_q;
			res_q <= '0;
			bit_q <= SQ_W'(1) << 54;
		end
		if (cmd.step) begin
			if ({1'b0, n_q} >= sq_sum) begin
				n_q   <= SQ_W'({1'b0, n_q} - sq_sum);
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
			if (nz_q && cmd.k < STEP_W'(CORDIC_ITERS)) begin
				if (cy_q >= 0) begin
					cx_q <= cx_q + sdx;
					cy_q <= cy_q - sdy;
					z_q  <= z_q + atan_deg(cmd.k);
				end else begin
					cx_q <= cx_q - sdx;
					cy_q <= cy_q + sdy;
					z_q  <= z_q - atan_deg(cmd.k);
				end
			end
		end
		if (cmd.fin)
			sp_q <= res_q[27:0] * RAD_TO_DEG_Q16;
		if (cmd.wr) begin
			spd_r_q[cmd.mod] <= !moving_q ? 24'd0 : ((s_full[25:24] != 2'd0) ? 24'hFFFFFF : s_full[23:0]);
			ang_r_q[cmd.mod] <= a_cl[16:0];
		end
		if (cmd.publish) begin
			spd_o_q  <= spd_r_q;
			ang_o_q  <= ang_r_q;
			moving   <= moving_q;
		end
	end

	assign speed_front_left  = spd_o_q[0];
	assign speed_front_right = spd_o_q[1];
	assign speed_back_left   = spd_o_q[2];
	assign speed_back_right  = spd_o_q[3];
	assign angle_front_left  = ang_o_q[0];
	assign angle_front_right = ang_o_q[1];
	assign angle_back_left   = ang_o_q[2];
	assign angle_back_right  = ang_o_q[3];
endmodule

[rtl/swerve_module_kinematics.sv]
// After an input transfer the block runs a setup step, then each of the four modules in turn,
// then publishes; it takes no new input until the result is published. Each module runs the
// 28-step square root on one shared unit, alongside its CORDIC.
// A new input is taken while the previous result still waits in the output register.
// Reset (arst_n low): config registers to defaults, held command to zero, no valid output.
// Depends on swk_pkg, swk_ctrl, swk_dp.
`timescale 1ns / 1ps
module swerve_module_kinematics (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [15:0] stick_x,
	input  logic signed [15:0] stick_y,
	input  logic signed [15:0] stick_rot,
	output logic out_valid,
	input  logic out_ready,
	output logic [23:0] speed_front_left,
	output logic [23:0] speed_front_right,
	output logic [23:0] speed_back_left,
	output logic [23:0] speed_back_right,
	output logic signed [16:0] angle_front_left,
	output logic signed [16:0] angle_front_right,
	output logic signed [16:0] angle_back_left,
	output logic signed [16:0] angle_back_right,
	output logic moving
);
	import swk_pkg::*;

	cmd_t cmd;

	swk_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd)
	);

	swk_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.stick_x(stick_x), .stick_y(stick_y), .stick_rot(stick_rot),
		.speed_front_left(speed_front_left), .speed_front_right(speed_front_right),
		.speed_back_left(speed_back_left), .speed_back_right(speed_back_right),
		.angle_front_left(angle_front_left), .angle_front_right(angle_front_right),
		.angle_back_left(angle_back_left), .angle_back_right(angle_back_right),
		.moving(moving)
	);
endmodule
